// ----- rtl/cch_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the compass heading block.
`timescale 1ns / 1ps

package cch_pkg;

  // Default build settings
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;

  // Width of the CORDIC x and y datapath: an 18-bit axis times 256 plus growth
  localparam int XY_W = 28;

  localparam int OFFSET_W = 16;
  localparam int SCALE_W  = 24;
  localparam int HEAD_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_DATA_W-1:0] SCALES_RESET = 48'h0002_0000_0200;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X_OFFSET     = 3'd0,
    REG_NORMAL_Y_OFFSET     = 3'd1,
    REG_MOTOR_X_OFFSET      = 3'd2,
    REG_MOTOR_Y_OFFSET      = 3'd3,
    REG_NORMAL_SCALES       = 3'd4,
    REG_MOTOR_SCALES        = 3'd5,
    REG_NORMAL_ORIGIN_ANGLE = 3'd6,
    REG_MOTOR_ORIGIN_ANGLE  = 3'd7
  } cch_reg_t;

  // Contents of the calibration register file
  typedef struct packed {
    logic signed [OFFSET_W-1:0]   normal_x_offset;
    logic signed [OFFSET_W-1:0]   normal_y_offset;
    logic signed [OFFSET_W-1:0]   motor_x_offset;
    logic signed [OFFSET_W-1:0]   motor_y_offset;
    logic        [CFG_DATA_W-1:0] normal_scales;
    logic        [CFG_DATA_W-1:0] motor_scales;
    logic signed [HEAD_W-1:0]     normal_origin_angle;
    logic signed [HEAD_W-1:0]     motor_origin_angle;
  } cch_cal_t;

  // Sideband that travels with each sample along the cell chain
  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic signed [HEAD_W-1:0] origin;
  } cch_side_t;

  // atan(2^-i), 2^32 units per full turn
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Rotation angle of step idx, rounded to abits bits per full turn
  function automatic logic [31:0] cch_atan_step(input int idx, input int abits);
    logic [32:0] sum;
    sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - abits));
    return 32'(sum >> (32 - abits));
  endfunction

endpackage

// ----- rtl/cch_regs.sv -----
// Calibration register file written through the configuration channel.
`timescale 1ns / 1ps

module cch_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [cch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cch_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           cfg_ready,
  output cch_pkg::cch_cal_t              cal
);
  import cch_pkg::*;

  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.normal_x_offset     <= '0;
      cal.normal_y_offset     <= '0;
      cal.motor_x_offset      <= '0;
      cal.motor_y_offset      <= '0;
      cal.normal_scales       <= SCALES_RESET;
      cal.motor_scales        <= SCALES_RESET;
      cal.normal_origin_angle <= '0;
      cal.motor_origin_angle  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cch_reg_t'(cfg_index))
        REG_NORMAL_X_OFFSET:     cal.normal_x_offset     <= cfg_data[OFFSET_W-1:0];
        REG_NORMAL_Y_OFFSET:     cal.normal_y_offset     <= cfg_data[OFFSET_W-1:0];
        REG_MOTOR_X_OFFSET:      cal.motor_x_offset      <= cfg_data[OFFSET_W-1:0];
        REG_MOTOR_Y_OFFSET:      cal.motor_y_offset      <= cfg_data[OFFSET_W-1:0];
        REG_NORMAL_SCALES:       cal.normal_scales       <= cfg_data;
        REG_MOTOR_SCALES:        cal.motor_scales        <= cfg_data;
        REG_NORMAL_ORIGIN_ANGLE: cal.normal_origin_angle <= cfg_data[HEAD_W-1:0];
        REG_MOTOR_ORIGIN_ANGLE:  cal.motor_origin_angle  <= cfg_data[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/cch_front.sv -----
// Front end: offset removal, scaling, saturation and CORDIC start vector.
`timescale 1ns / 1ps

module cch_front #(
  parameter int ANGLE_BITS = cch_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [15:0]                  raw_x,
  input  logic signed [15:0]                  raw_y,
  input  logic                                use_motor_set,
  input  logic                                upright,
  input  cch_pkg::cch_cal_t                   cal,
  output logic signed [cch_pkg::XY_W-1:0]     x0,
  output logic signed [cch_pkg::XY_W-1:0]     y0,
  output logic        [ANGLE_BITS-1:0]        z0,
  output cch_pkg::cch_side_t                  side0
);
  import cch_pkg::*;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // Stage A: select set, subtract offsets, mirror origin
  logic                     a_valid;
  logic                     a_up;
  logic signed [16:0]       a_dx;
  logic signed [16:0]       a_dy;
  logic        [SCALE_W-1:0] a_sx;
  logic        [SCALE_W-1:0] a_sy;
  logic signed [HEAD_W-1:0] a_org;

  logic signed [OFFSET_W-1:0] sel_xo;
  logic signed [OFFSET_W-1:0] sel_yo;
  logic        [CFG_DATA_W-1:0] sel_sc;
  logic signed [HEAD_W-1:0]   sel_org;
  logic signed [16:0]         org_ext;
  logic signed [16:0]         org_m;

  always_comb begin
    sel_xo  = use_motor_set ? cal.motor_x_offset      : cal.normal_x_offset;
    sel_yo  = use_motor_set ? cal.motor_y_offset      : cal.normal_y_offset;
    sel_sc  = use_motor_set ? cal.motor_scales        : cal.normal_scales;
    sel_org = use_motor_set ? cal.motor_origin_angle  : cal.normal_origin_angle;
    org_ext = 17'(sel_org);
    if (upright) begin
      org_m = org_ext;
    end else if (sel_org > 0) begin
      org_m = 17'sd32768 - org_ext;
    end else begin
      org_m = -17'sd32768 - org_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_up  <= upright;
    a_dx  <= 17'(raw_x) - 17'(sel_xo);
    a_dy  <= 17'(raw_y) - 17'(sel_yo);
    a_sx  <= sel_sc[SCALE_W-1:0];
    a_sy  <= sel_sc[2*SCALE_W-1:SCALE_W];
    a_org <= org_m[HEAD_W-1:0];
  end

  // Stage B: one multiplier per axis
  logic                     b_valid;
  logic                     b_up;
  logic signed [41:0]       b_px;
  logic signed [41:0]       b_py;
  logic signed [HEAD_W-1:0] b_org;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_up  <= a_up;
    b_px  <= 42'(a_dx) * 42'($signed({1'b0, a_sx}));
    b_py  <= 42'(a_dy) * 42'($signed({1'b0, a_sy}));
    b_org <= a_org;
  end

  // Stage C: floor to Q1.15, clamp to [-1, 1], build the start vector
  function automatic logic signed [17:0] sat_q15(input logic signed [41:0] p);
    logic signed [41:0] q;
    q = p >>> 5;
    if (q > 42'sd32768) begin
      return 18'sd32768;
    end else if (q < -42'sd32768) begin
      return -18'sd32768;
    end else begin
      return q[17:0];
    end
  endfunction

  logic signed [17:0] c_dx;
  logic signed [17:0] c_dy;
  logic signed [17:0] c_a;

  always_comb begin
    c_dx = sat_q15(b_px);
    c_dy = sat_q15(b_py);
    c_a  = b_up ? c_dx : -c_dx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side0.valid <= 1'b0;
    end else begin
      side0.valid <= b_valid;
    end
    side0.zero   <= (c_a == '0) && (c_dy == '0);
    side0.origin <= b_org;
    // Fold the left half plane onto the right and start from pi
    if (c_dy < 0) begin
      x0 <= XY_W'(-c_dy) <<< 8;
      y0 <= XY_W'(-c_a) <<< 8;
      z0 <= HALF_TURN;
    end else begin
      x0 <= XY_W'(c_dy) <<< 8;
      y0 <= XY_W'(c_a) <<< 8;
      z0 <= '0;
    end
  end

endmodule

// ----- rtl/cch_cell.sv -----
// One vectoring CORDIC step, registered, handing its vector to the next cell.
`timescale 1ns / 1ps

module cch_cell #(
  parameter int ANGLE_BITS = cch_pkg::ANGLE_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic signed [cch_pkg::XY_W-1:0] x_in,
  input  logic signed [cch_pkg::XY_W-1:0] y_in,
  input  logic        [ANGLE_BITS-1:0]    z_in,
  input  cch_pkg::cch_side_t              side_in,
  output logic signed [cch_pkg::XY_W-1:0] x_out,
  output logic signed [cch_pkg::XY_W-1:0] y_out,
  output logic        [ANGLE_BITS-1:0]    z_out,
  output cch_pkg::cch_side_t              side_out
);
  import cch_pkg::*;

  localparam logic [ANGLE_BITS-1:0] STEP = ANGLE_BITS'(cch_atan_step(IDX, ANGLE_BITS));

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.zero   <= side_in.zero;
    side_out.origin <= side_in.origin;
    // Residual y of zero or more: rotate clockwise
    if (!y_in[XY_W-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + STEP;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - STEP;
    end
  end

endmodule

// ----- rtl/calibrated_compass_heading.sv -----
// Top level of the calibrated compass heading pipeline.
`timescale 1ns / 1ps

// Calibrated compass heading. Pulse start with a raw two-axis sample; the block
// is never busy outside reset, so it takes a new sample on every clock cycle.
// Each sample yields exactly one result, shown for a single cycle with done high,
// after three front-end stages (offset subtract, scale multiply, clamp and start
// vector), one registered cell per CORDIC step, and the output register.
// The receiver cannot stall done, so it must take every result as it comes.
// Results leave in the order the samples came in. Angles are binary: 32768
// means pi, and an angle of exactly pi reads as -pi. sensor_heading is
// atan2(+/-dx, dy) after calibration; map_heading is that heading minus the
// selected origin (mirrored when the sensor is upside down), wrapped mod 2pi.
// Write calibration registers only while no sample is in flight.
module calibrated_compass_heading #(
  parameter int CORDIC_STAGES = cch_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = cch_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Sample command
  input  logic                           start,
  output logic                           busy,
  input  logic signed [15:0]             raw_x,
  input  logic signed [15:0]             raw_y,
  input  logic                           use_motor_set,
  input  logic                           upright,
  // Result strobe
  output logic                           done,
  output logic signed [15:0]             map_heading,
  output logic signed [15:0]             sensor_heading,
  // Calibration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cch_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cch_pkg::*;

  // Hold off new samples only while reset is asserted
  assign busy = rst;

  logic     in_valid;
  cch_cal_t cal;

  assign in_valid = start & ~busy;

  cch_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cal       (cal)
  );

  // Taps between cells: entry 0 comes from the front end, entry k from cell k-1
  logic signed [XY_W-1:0]       xv   [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]       yv   [CORDIC_STAGES+1];
  logic        [ANGLE_BITS-1:0] zv   [CORDIC_STAGES+1];
  cch_side_t                    side [CORDIC_STAGES+1];

  cch_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .raw_x         (raw_x),
    .raw_y         (raw_y),
    .use_motor_set (use_motor_set),
    .upright       (upright),
    .cal           (cal),
    .x0            (xv[0]),
    .y0            (yv[0]),
    .z0            (zv[0]),
    .side0         (side[0])
  );

  // Chain of rotation cells, one step of the CORDIC each
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    cch_cell #(
      .ANGLE_BITS (ANGLE_BITS),
      .IDX        (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .x_in     (xv[k]),
      .y_in     (yv[k]),
      .z_in     (zv[k]),
      .side_in  (side[k]),
      .x_out    (xv[k+1]),
      .y_out    (yv[k+1]),
      .z_out    (zv[k+1]),
      .side_out (side[k+1])
    );
  end

  // Zero vector has angle zero regardless of what the cells accumulated
  logic [ANGLE_BITS-1:0] z_fin;
  logic [HEAD_W-1:0]     head16;
  cch_side_t             side_fin;

  assign side_fin = side[CORDIC_STAGES];
  assign z_fin    = side_fin.zero ? '0 : zv[CORDIC_STAGES];

  // Rescale to a 16-bit angle: floor when wider, shift left when narrower
  if (ANGLE_BITS >= HEAD_W) begin : g_floor
    assign head16 = z_fin[ANGLE_BITS-1 -: HEAD_W];
  end else begin : g_widen
    assign head16 = {z_fin, {(HEAD_W - ANGLE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_fin.valid;
    end
    sensor_heading <= head16;
    // Subtract origin modulo one full turn
    map_heading    <= head16 - side_fin.origin;
  end

endmodule

// ----- tb/sv/calibrated_compass_heading_checker.sv -----
// Checker for the compass heading block: predicts each heading and compares results.
`timescale 1ns / 1ps

module calibrated_compass_heading_checker #(
  parameter int STAGES = cch_pkg::CORDIC_STAGES_DEF,
  parameter int ANG    = cch_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic signed [15:0]               raw_x,
  input  logic signed [15:0]               raw_y,
  input  logic                             use_motor_set,
  input  logic                             upright,
  input  logic                             done,
  input  logic signed [15:0]               map_heading,
  input  logic signed [15:0]               sensor_heading,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [cch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cch_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               checked
);
  import cch_pkg::*;

  typedef struct packed {
    logic signed [15:0] map;
    logic signed [15:0] sensor;
  } heading_t;

  cch_cal_t cal;
  heading_t expected_headings[$];
  heading_t got;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // atan(2^-i), 2^32 units per full turn
  function automatic longint atan_turn(input int i);
    case (i)
      0: return 536870912;  1: return 316933406;  2: return 167458907;
      3: return 85004756;   4: return 42667331;   5: return 21354465;
      6: return 10679838;   7: return 5340245;    8: return 2670163;
      9: return 1335087;    10: return 667544;    11: return 333772;
      12: return 166886;    13: return 83443;     14: return 41722;
      15: return 20861;     16: return 10430;     17: return 5215;
      18: return 2608;      19: return 1304;      20: return 652;
      21: return 326;       22: return 163;       default: return 81;
    endcase
  endfunction

  // Offset, scale in Q4.20, floor to Q1.15 and clamp to [-1, 1]
  function automatic longint saturate_axis(input longint raw, input longint off,
                                           input longint scale);
    longint p;
    p = ((raw - off) * scale) >>> 5;
    if (p > 32768) p = 32768;
    if (p < -32768) p = -32768;
    return p;
  endfunction

  function automatic logic signed [15:0] cordic_heading(input longint ya, input longint xb);
    longint x, y, xs, ys, t;
    logic [ANG-1:0] z;
    logic signed [ANG-1:0] zs;
    int i;
    if (xb == 0 && ya == 0) return '0;
    x = xb * 256;
    y = ya * 256;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = {1'b1, {(ANG-1){1'b0}}};
    end
    for (i = 0; i < STAGES && i < 24; i++) begin
      t  = (atan_turn(i) + (longint'(1) << (31 - ANG))) >> (32 - ANG);
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + t[ANG-1:0];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - t[ANG-1:0];
      end
    end
    zs = z;
    if (ANG >= 16) return 16'(zs >>> (ANG - 16));
    return 16'(longint'(zs) * (longint'(1) << (16 - ANG)));
  endfunction

  function automatic heading_t predict_heading(input logic signed [15:0] rx,
                                               input logic signed [15:0] ry,
                                               input logic motor, input logic up);
    longint xo, yo, org, dx, dy;
    logic [CFG_DATA_W-1:0] sc;
    logic signed [15:0] head;
    heading_t h;
    xo  = motor ? cal.motor_x_offset : cal.normal_x_offset;
    yo  = motor ? cal.motor_y_offset : cal.normal_y_offset;
    sc  = motor ? cal.motor_scales : cal.normal_scales;
    org = motor ? cal.motor_origin_angle : cal.normal_origin_angle;
    dx  = saturate_axis(rx, xo, sc[23:0]);
    dy  = saturate_axis(ry, yo, sc[47:24]);
    if (!up) dx = -dx;
    head = cordic_heading(dx, dy);
    // Upside down: mirror the origin about the y axis
    if (!up) org = (org > 0) ? 32768 - org : -32768 - org;
    h.sensor = head;
    h.map    = 16'(longint'(head) - org);
    return h;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cal = '0;
      cal.normal_scales = SCALES_RESET;
      cal.motor_scales  = SCALES_RESET;
      expected_headings.delete();
    end else begin
      if (done === 1'b1) begin
        if (expected_headings.size() == 0) begin
          report_mismatch($sformatf("result map %0d sensor %0d with nothing expected",
                                    map_heading, sensor_heading));
        end else begin
          got = expected_headings.pop_front();
          checked++;
          if (map_heading !== got.map)
            report_mismatch($sformatf("map_heading %0d, expected %0d", map_heading, got.map));
          if (sensor_heading !== got.sensor)
            report_mismatch($sformatf("sensor_heading %0d, expected %0d",
                                      sensor_heading, got.sensor));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cch_reg_t'(cfg_index))
          REG_NORMAL_X_OFFSET:     cal.normal_x_offset     = cfg_data[15:0];
          REG_NORMAL_Y_OFFSET:     cal.normal_y_offset     = cfg_data[15:0];
          REG_MOTOR_X_OFFSET:      cal.motor_x_offset      = cfg_data[15:0];
          REG_MOTOR_Y_OFFSET:      cal.motor_y_offset      = cfg_data[15:0];
          REG_NORMAL_SCALES:       cal.normal_scales       = cfg_data;
          REG_MOTOR_SCALES:        cal.motor_scales        = cfg_data;
          REG_NORMAL_ORIGIN_ANGLE: cal.normal_origin_angle = cfg_data[15:0];
          REG_MOTOR_ORIGIN_ANGLE:  cal.motor_origin_angle  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_headings.push_back(predict_heading(raw_x, raw_y, use_motor_set, upright));
    end
    pending = expected_headings.size();
  end

endmodule

// ----- tb/sv/calibrated_compass_heading_tb.sv -----
// Testbench top for the compass heading block: stimulus, calibration phases and verdict.
`timescale 1ns / 1ps

module calibrated_compass_heading_tb;
  import cch_pkg::*;

  // Pipeline depth as given for the block: front end, CORDIC cells, output register
  localparam int LATENCY         = CORDIC_STAGES_DEF + 4;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_LIMIT     = 1000;
  // Leave a wide margin over the slowest run
  localparam int LIMIT_CYCLES    = 200000;

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  start          = 1'b0;
  logic                  busy;
  logic signed [15:0]    raw_x          = '0;
  logic signed [15:0]    raw_y          = '0;
  logic                  use_motor_set  = 1'b0;
  logic                  upright        = 1'b1;
  logic                  done;
  logic signed [15:0]    map_heading;
  logic signed [15:0]    sensor_heading;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int sample_count = 0;
  int directed_count = 0;

  // Offsets last written, kept so random samples can land near the zero point
  int off_x[2];
  int off_y[2];

  always #5 clk = ~clk;

  calibrated_compass_heading #(
    .CORDIC_STAGES(CORDIC_STAGES_DEF),
    .ANGLE_BITS   (ANGLE_BITS_DEF)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .raw_x         (raw_x),
    .raw_y         (raw_y),
    .use_motor_set (use_motor_set),
    .upright       (upright),
    .done          (done),
    .map_heading   (map_heading),
    .sensor_heading(sensor_heading),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  calibrated_compass_heading_checker #(
    .STAGES(CORDIC_STAGES_DEF),
    .ANG   (ANGLE_BITS_DEF)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .raw_x         (raw_x),
    .raw_y         (raw_y),
    .use_motor_set (use_motor_set),
    .upright       (upright),
    .done          (done),
    .map_heading   (map_heading),
    .sensor_heading(sensor_heading),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("** calibrated_compass_heading: FAILED **");
      $finish;
    end
  end

  // Present one sample at the falling edge and hold it until the block takes it.
  // Start stays high from one sample to the next, so back-to-back transactions
  // never lower and raise it in the same step.
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic motor, input logic up);
    @(negedge clk);
    start         <= 1'b1;
    raw_x         <= x;
    raw_y         <= y;
    use_motor_set <= motor;
    upright       <= up;
    do @(posedge clk); while (busy !== 1'b0);
    sample_count++;
  endtask

  // Write one calibration register; cfg_valid is left high for a following write
  task automatic write_reg(input cch_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Drop start, wait for every expected result, then let the pipe run empty
  task automatic wait_idle();
    int k;
    @(negedge clk);
    start <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Load a full calibration: one extreme high, one extreme low, otherwise random.
  // The unused upper data bits of the 16-bit registers carry junk on purpose.
  task automatic load_setting(input int kind);
    int s, k;
    logic [23:0] sx, sy;
    logic [15:0] ox, oy, org;
    for (s = 0; s < 2; s++) begin
      case (kind)
        1: begin
          ox = 16'sh7fff;  oy = 16'sh7fff;  org = 16'sh7fff;
          sx = '1;         sy = '1;
        end
        3: begin
          ox = 16'sh8000;  oy = 16'sh8000;  org = 16'sh8000;
          sx = (s == 0) ? 24'd0 : 24'd1;
          sy = sx;
        end
        default: begin
          ox  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
          oy  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
          org = 16'($urandom);
          // Spread scales over many octaves so both the linear and the clamped
          // regions are hit
          k  = $urandom_range(0, 23);
          sx = 24'($urandom_range(0, 1 << k));
          k  = $urandom_range(0, 23);
          sy = 24'($urandom_range(0, 1 << k));
        end
      endcase
      off_x[s] = $signed(ox);
      off_y[s] = $signed(oy);
      if (s == 0) begin
        write_reg(REG_NORMAL_X_OFFSET,     {32'($urandom), ox});
        write_reg(REG_NORMAL_Y_OFFSET,     {32'($urandom), oy});
        write_reg(REG_NORMAL_SCALES,       {sy, sx});
        write_reg(REG_NORMAL_ORIGIN_ANGLE, {32'($urandom), org});
      end else begin
        write_reg(REG_MOTOR_X_OFFSET,      {32'($urandom), ox});
        write_reg(REG_MOTOR_Y_OFFSET,      {32'($urandom), oy});
        write_reg(REG_MOTOR_SCALES,        {sy, sx});
        write_reg(REG_MOTOR_ORIGIN_ANGLE,  {32'($urandom), org});
      end
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase, n, idle_pct, r, span, sel;
    logic motor, up;
    logic [15:0] x, y;

    off_x = '{0, 0};
    off_y = '{0, 0};

    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples under the reset calibration: offsets 0, scales 1/2048,
    // origins 0. An axis of 2048 lands exactly on +1, 2049 is clamped.
    send_sample(16'd0, 16'd0, 1'b0, 1'b1);          // zero vector
    send_sample(16'd0, 16'd0, 1'b1, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 1'b0, 1'b1);  // both axes at the top
    send_sample(16'sh8000, 16'sh8000, 1'b0, 1'b1);  // both at the bottom
    send_sample(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
    send_sample(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
    send_sample(16'd0, -16'sd100, 1'b0, 1'b1);      // negative dy on the axis: near pi
    send_sample(16'd0, -16'sd100, 1'b0, 1'b0);
    send_sample(16'd100, 16'd0, 1'b0, 1'b1);        // dy of zero, residual sign rule
    send_sample(-16'sd100, 16'd0, 1'b0, 1'b1);
    send_sample(16'd100, 16'd0, 1'b1, 1'b0);
    send_sample(16'd0, 16'd100, 1'b0, 1'b1);
    send_sample(16'd100, 16'd100, 1'b0, 1'b1);
    send_sample(-16'sd100, -16'sd100, 1'b0, 1'b0);
    send_sample(16'd100, -16'sd100, 1'b1, 1'b1);
    send_sample(-16'sd100, 16'd100, 1'b1, 1'b0);
    send_sample(16'd1, -16'sd1, 1'b0, 1'b1);
    send_sample(16'd2048, -16'sd2049, 1'b0, 1'b1);  // exact +1 against a clamped axis
    send_sample(-16'sd2048, 16'd2048, 1'b0, 1'b0);
    send_sample(16'd3, -16'sd5, 1'b1, 1'b1);
    directed_count = sample_count;

    // Random phases: each loads a new calibration while idle, then streams
    // samples with its own idle mix
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      load_setting(phase);
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 58;
        default: idle_pct = 11;
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Idle the sender one cycle at a time, so idle_pct is the idle share of cycles
        while ($urandom_range(0, 99) < idle_pct) begin
          @(negedge clk);
          start <= 1'b0;
        end
        motor = 1'($urandom);
        up    = 1'($urandom);
        r     = $urandom_range(0, 9);
        span  = 1 << $urandom_range(1, 13);
        sel   = motor;
        if (r < 2) begin
          // Raw noise over the full range
          x = 16'($urandom);
          y = 16'($urandom);
        end else if (r == 2) begin
          // One axis sits exactly on its offset
          x = 16'(off_x[sel]);
          y = 16'(off_y[sel] + int'($urandom_range(0, 2 * span)) - span);
          if ($urandom_range(0, 1) == 1) begin
            x = 16'(off_x[sel] + int'($urandom_range(0, 2 * span)) - span);
            y = 16'(off_y[sel]);
          end
        end else begin
          // Around the hard-iron center, where the heading is meaningful
          x = 16'(off_x[sel] + int'($urandom_range(0, 2 * span)) - span);
          y = 16'(off_y[sel] + int'($urandom_range(0, 2 * span)) - span);
        end
        send_sample(x, y, motor, up);
      end
    end

    wait_idle();

    $display("covered %0d samples (%0d directed) over %0d calibration settings,",
             sample_count, directed_count, NUM_PHASES + 1);
    $display("both register extremes and idle mixes of 0, 58 and 11 percent; %0d results compared",
             checked);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** calibrated_compass_heading: PASSED **");
    end else begin
      $display("** calibrated_compass_heading: FAILED **");
    end
    $finish;
  end

endmodule
